### hdl/fcbq_pkg.sv
// Shared types and codes for the framed command byte queue.
// No dependencies; imported by fcbq_ctrl, fcbq_datapath, the top level and the bench.
package fcbq_pkg;

   // Request opcodes
   localparam logic [1:0] OPC_OPEN   = 2'd0;
   localparam logic [1:0] OPC_APPEND = 2'd1;
   localparam logic [1:0] OPC_POP    = 2'd2;

   // Response status codes
   localparam logic [2:0] ST_OPEN_EMPTY = 3'd0;
   localparam logic [2:0] ST_OPEN_BUSY  = 3'd1;
   localparam logic [2:0] ST_NO_ROOM    = 3'd2;
   localparam logic [2:0] ST_POPPED     = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_STRAY      = 3'd5;

   localparam logic [7:0] EMPTY_BYTE  = 8'hFF;
   localparam int         HEADER_LEN  = 2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic [7:0] send_length;
      logic [7:0] receive_length;
   } req_item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_OPEN_LEN,
      S_HDR_LEN,
      S_DATA,
      S_DONE
   } state_type;

   // One datapath operation per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_REFUSE,
      OP_OPEN_RX,
      OP_OPEN_LEN,
      OP_APPEND,
      OP_STRAY,
      OP_POP_EMPTY,
      OP_TAKE_RX,
      OP_TAKE_LEN,
      OP_TAKE_DATA,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      req_ready;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       open_ok;
      logic       appends_owed;
      logic       pop_ready;
      logic       seq_active;
      logic       rsp_free;
   } dp_status_type;

endpackage

### hdl/fcbq_channels.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing; used by the top level of the queue.
interface fcbq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   logic [7:0] send_length;
   logic [7:0] receive_length;

   modport source (output valid, opcode, data_byte, send_length, receive_length,
                   input ready);
   modport sink   (input valid, opcode, data_byte, send_length, receive_length,
                   output ready);
endinterface

interface fcbq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] out_byte;
   logic       last_of_sequence;
   logic       first_of_sequence;
   logic [7:0] expected_receive;

   modport source (output valid, status, out_byte, last_of_sequence,
                   first_of_sequence, expected_receive, input ready);
   modport sink   (input valid, status, out_byte, last_of_sequence,
                   first_of_sequence, expected_receive, output ready);
endinterface

### hdl/fcbq_ctrl.sv
// Controller state machine: sequences each request beat through the datapath.
// Depends on fcbq_pkg.
module fcbq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fcbq_pkg::dp_status_type dp_status,
   output fcbq_pkg::ctl_cmd_type ctl_cmd
);
   import fcbq_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (dp_status.opcode)
               OPC_OPEN: begin
                  state_in = dp_status.open_ok ? S_OPEN_LEN : S_DONE;
               end
               OPC_POP: begin
                  if (!dp_status.pop_ready)      state_in = S_DONE;
                  else if (dp_status.seq_active) state_in = S_DATA;
                  else                           state_in = S_HDR_LEN;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_OPEN_LEN: state_in = S_DONE;
         S_HDR_LEN:  state_in = S_DATA;
         S_DATA:     state_in = S_DONE;
         S_DONE: begin
            if (dp_status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl_cmd.op        = OP_NONE;
      ctl_cmd.req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ctl_cmd.req_ready = 1'b1;
            if (req_valid) ctl_cmd.op = OP_LATCH;
         end
         S_DECODE: begin
            case (dp_status.opcode)
               OPC_OPEN:   ctl_cmd.op = dp_status.open_ok ? OP_OPEN_RX : OP_REFUSE;
               OPC_APPEND: ctl_cmd.op = dp_status.appends_owed ? OP_APPEND : OP_STRAY;
               OPC_POP: begin
                  if (!dp_status.pop_ready)      ctl_cmd.op = OP_POP_EMPTY;
                  else if (dp_status.seq_active) ctl_cmd.op = OP_NONE;
                  else                           ctl_cmd.op = OP_TAKE_RX;
               end
               default: ctl_cmd.op = OP_STRAY;
            endcase
         end
         S_OPEN_LEN: ctl_cmd.op = OP_OPEN_LEN;
         S_HDR_LEN:  ctl_cmd.op = OP_TAKE_LEN;
         S_DATA:     ctl_cmd.op = OP_TAKE_DATA;
         S_DONE: begin
            if (dp_status.rsp_free) ctl_cmd.op = OP_PUBLISH;
         end
         default: ctl_cmd.op = OP_NONE;
      endcase
   end

   // An accepted beat is always decoded next
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
      else $error("accepted beat not decoded");

   // Header length is read right after the receive count header
   a_hdr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDR_LEN) |-> ($past(state_ff) == S_DECODE))
      else $error("header length read out of order");

endmodule

### hdl/fcbq_datapath.sv
// Datapath: byte ring memory, indexes, sequence counters and response register.
// Depends on fcbq_pkg; driven by fcbq_ctrl commands.
module fcbq_datapath #(
   parameter int CAPACITY = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fcbq_pkg::req_item_type  req_item,
   input  fcbq_pkg::ctl_cmd_type   ctl_cmd,
   output fcbq_pkg::dp_status_type dp_status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_of_sequence,
   output logic                    rsp_first_of_sequence,
   output logic [7:0]              rsp_expected_receive
);
   import fcbq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int OW = IW + 1;
   localparam int CW = ((OW > 9) ? OW : 9) + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   // Ring storage, no reset
   logic [7:0] store_mem [CAPACITY];
   logic [7:0] rd_data_ff;
   logic       wr_en;
   logic [7:0] wr_data;

   req_item_type  item_ff, item_in;
   logic [IW-1:0] read_index_ff, read_index_in;
   logic [IW-1:0] write_index_ff, write_index_in;
   logic [7:0]    bytes_left_ff, bytes_left_in;
   logic [7:0]    receive_count_ff, receive_count_in;
   logic [7:0]    appends_pending_ff, appends_pending_in;

   // Staged result
   logic [2:0] stg_status_ff, stg_status_in;
   logic [7:0] stg_byte_ff, stg_byte_in;
   logic       stg_last_ff, stg_last_in;
   logic       stg_first_ff, stg_first_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_first_ff, rsp_first_in;
   logic [7:0] rsp_recv_ff, rsp_recv_in;

   logic [OW-1:0] occupancy;
   logic [OW-1:0] room;
   logic [CW-1:0] need;
   logic [IW-1:0] read_next;
   logic [IW-1:0] write_next;

   // Ring arithmetic
   always_comb begin
      if (write_index_ff >= read_index_ff) begin
         occupancy = OW'(write_index_ff) - OW'(read_index_ff);
      end else begin
         occupancy = OW'(write_index_ff) + OW'(CAPACITY) - OW'(read_index_ff);
      end
      room       = OW'(CAPACITY - 1) - occupancy;
      need       = CW'(item_ff.send_length) + CW'(HEADER_LEN);
      read_next  = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
      write_next = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
   end

   // Status to controller
   always_comb begin
      dp_status.opcode       = item_ff.opcode;
      dp_status.open_ok      = (appends_pending_ff == 8'd0) &&
                               (item_ff.send_length != 8'd0) &&
                               (need <= CW'(room));
      dp_status.appends_owed = (appends_pending_ff != 8'd0);
      dp_status.pop_ready    = (bytes_left_ff == 8'd0) ? (occupancy >= OW'(3))
                                                       : (occupancy >= OW'(1));
      dp_status.seq_active   = (bytes_left_ff != 8'd0);
      dp_status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Next values per command
   always_comb begin
      item_in            = item_ff;
      read_index_in      = read_index_ff;
      write_index_in     = write_index_ff;
      bytes_left_in      = bytes_left_ff;
      receive_count_in   = receive_count_ff;
      appends_pending_in = appends_pending_ff;
      stg_status_in      = stg_status_ff;
      stg_byte_in        = stg_byte_ff;
      stg_last_in        = stg_last_ff;
      stg_first_in       = stg_first_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_byte_in        = rsp_byte_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_first_in       = rsp_first_ff;
      rsp_recv_in        = rsp_recv_ff;
      wr_en              = 1'b0;
      wr_data            = 8'd0;
      case (ctl_cmd.op)
         OP_LATCH: begin
            item_in       = req_item;
            stg_status_in = ST_STRAY;
            stg_byte_in   = 8'd0;
            stg_last_in   = 1'b0;
            stg_first_in  = 1'b0;
         end
         OP_REFUSE: stg_status_in = ST_NO_ROOM;
         OP_OPEN_RX: begin
            wr_en          = 1'b1;
            wr_data        = item_ff.receive_length;
            write_index_in = write_next;
            stg_status_in  = (occupancy == '0) ? ST_OPEN_EMPTY : ST_OPEN_BUSY;
         end
         OP_OPEN_LEN: begin
            wr_en              = 1'b1;
            wr_data            = item_ff.send_length;
            write_index_in     = write_next;
            appends_pending_in = item_ff.send_length;
         end
         OP_APPEND: begin
            wr_en              = 1'b1;
            wr_data            = item_ff.data_byte;
            write_index_in     = write_next;
            appends_pending_in = appends_pending_ff - 8'd1;
            stg_status_in      = ST_OPEN_BUSY;
         end
         OP_STRAY: stg_status_in = ST_STRAY;
         OP_POP_EMPTY: begin
            stg_status_in = ST_EMPTY;
            stg_byte_in   = EMPTY_BYTE;
         end
         OP_TAKE_RX: begin
            receive_count_in = rd_data_ff;
            read_index_in    = read_next;
            stg_first_in     = 1'b1;
         end
         OP_TAKE_LEN: begin
            bytes_left_in = rd_data_ff;
            read_index_in = read_next;
         end
         OP_TAKE_DATA: begin
            // zero length header still yields its byte, flagged last
            stg_byte_in   = rd_data_ff;
            read_index_in = read_next;
            bytes_left_in = (bytes_left_ff == 8'd0) ? 8'd0 : bytes_left_ff - 8'd1;
            stg_last_in   = (bytes_left_ff <= 8'd1);
            stg_status_in = ST_POPPED;
         end
         OP_PUBLISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = stg_status_ff;
            rsp_byte_in   = stg_byte_ff;
            rsp_last_in   = stg_last_ff;
            rsp_first_in  = stg_first_ff;
            rsp_recv_in   = receive_count_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff      <= '0;
         write_index_ff     <= '0;
         bytes_left_ff      <= 8'd0;
         receive_count_ff   <= 8'd0;
         appends_pending_ff <= 8'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         read_index_ff      <= read_index_in;
         write_index_ff     <= write_index_in;
         bytes_left_ff      <= bytes_left_in;
         receive_count_ff   <= receive_count_in;
         appends_pending_ff <= appends_pending_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      stg_status_ff <= stg_status_in;
      stg_byte_ff   <= stg_byte_in;
      stg_last_ff   <= stg_last_in;
      stg_first_ff  <= stg_first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_recv_ff   <= rsp_recv_in;
   end

   // Ring write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[write_index_ff] <= wr_data;
      end
   end

   // Ring read port: follows the next read index every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[read_index_in];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_out_byte          = rsp_byte_ff;
   assign rsp_last_of_sequence  = rsp_last_ff;
   assign rsp_first_of_sequence = rsp_first_ff;
   assign rsp_expected_receive  = rsp_recv_ff;

   // One slot always stays free
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OW'(CAPACITY - 1))
      else $error("ring overfilled");

   // Sequence flags only accompany a popped byte
   a_flags_popped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_last_ff || rsp_first_ff)) |-> (rsp_status_ff == ST_POPPED))
      else $error("sequence flag on non-pop response");

   // Empty pop returns the fill byte
   a_empty_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_byte_ff == EMPTY_BYTE))
      else $error("empty pop byte wrong");

endmodule

### hdl/framed_command_byte_queue_unit.sv
// Framed command byte queue: a byte ring of CAPACITY entries holding bus
// transfer sequences, each stored as a receive-count header, a send-length
// header and its data bytes. Request beats carry an opcode (open, append,
// pop); every request yields exactly one response beat. Requests are handled
// one at a time: an append, a refused open, a stray or unknown opcode or an
// empty pop is decoded and its result published; an open writes its two
// headers in turn; a pop that starts a sequence reads the receive count, the
// send length and a data byte in turn, and a pop inside a running sequence
// reads one data byte. The ring memory has one write port and one registered
// read port, each moving one byte per cycle. A finished response waits in an
// output register, so a new request is taken while the previous response is
// still pending. The ring needs no clearing after reset.
// Depends on fcbq_pkg, fcbq_channels, fcbq_ctrl and fcbq_datapath.
module framed_command_byte_queue_unit #(
   parameter int CAPACITY = 512
) (
   input logic        clock,
   input logic        reset,
   fcbq_req_if.sink   req_bus,
   fcbq_rsp_if.source rsp_bus
);
   import fcbq_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;
   req_item_type  req_item;

   assign req_item.opcode         = req_bus.opcode;
   assign req_item.data_byte      = req_bus.data_byte;
   assign req_item.send_length    = req_bus.send_length;
   assign req_item.receive_length = req_bus.receive_length;
   assign req_bus.ready           = ctl_cmd.req_ready;

   fcbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   fcbq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_item              (req_item),
      .ctl_cmd               (ctl_cmd),
      .dp_status             (dp_status),
      .rsp_ready             (rsp_bus.ready),
      .rsp_valid             (rsp_bus.valid),
      .rsp_status            (rsp_bus.status),
      .rsp_out_byte          (rsp_bus.out_byte),
      .rsp_last_of_sequence  (rsp_bus.last_of_sequence),
      .rsp_first_of_sequence (rsp_bus.first_of_sequence),
      .rsp_expected_receive  (rsp_bus.expected_receive)
   );

endmodule

### bench/tb.sv
// Self-checking bench for the framed command byte queue: directed, fill/drain and random beats.
// Depends on fcbq_pkg, fcbq_channels and framed_command_byte_queue_unit; predicts every
// response from a shadow copy of the ring and compares it field by field.
`timescale 1ns / 100ps

module tb;
   import fcbq_pkg::*;

   localparam int         RING_DEPTH       = 512;
   localparam logic [1:0] OPC_UNUSED       = 2'd3;
   localparam int         TIMEOUT_NS       = 8_000_000;
   localparam int         CLOSE_OUT_CYCLES = 20;
   localparam int         RANDOM_BEATS     = 330;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       last_of_sequence;
      logic       first_of_sequence;
      logic [7:0] expected_receive;
   } queue_answer_type;

   logic clock;
   logic reset;

   fcbq_req_if req_ch();
   fcbq_rsp_if rsp_ch();

   framed_command_byte_queue_unit #(
      .CAPACITY(RING_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   // Shadow of the ring and its sequencing state
   logic [7:0]       shadow_ring [RING_DEPTH];
   logic [8:0]       shadow_rd;
   logic [8:0]       shadow_wr;
   logic [7:0]       seq_left;
   logic [7:0]       rx_count;
   logic [7:0]       owed_appends;
   logic [2:0]       last_status;
   queue_answer_type answers_due [$];
   int               failures;
   bit               no_idling;
   int               hold_low;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #TIMEOUT_NS;
      $display("FAILURE");
      $finish;
   end

   // Ring depth is a power of two, so 9-bit index arithmetic wraps for free
   function automatic logic [8:0] ring_fill();
      return shadow_wr - shadow_rd;
   endfunction

   function automatic void ring_put(logic [7:0] value);
      shadow_ring[shadow_wr] = value;
      shadow_wr = shadow_wr + 9'd1;
   endfunction

   function automatic logic [7:0] ring_take();
      logic [7:0] value;
      value = shadow_ring[shadow_rd];
      shadow_rd = shadow_rd + 9'd1;
      return value;
   endfunction

   // Computes the response to one accepted beat and advances the shadow state
   function automatic queue_answer_type predict_answer(req_item_type beat);
      queue_answer_type ans;
      logic [8:0]       occ;
      int               room;
      bit               can_pop;
      ans = '0;
      ans.status = ST_STRAY;
      occ = ring_fill();
      case (beat.opcode)
         OPC_OPEN: begin
            room = RING_DEPTH - 1 - int'(occ);
            if (owed_appends != 0 || beat.send_length == 0 ||
                int'(beat.send_length) + HEADER_LEN > room) begin
               ans.status = ST_NO_ROOM;
            end else begin
               ans.status = (occ == 0) ? ST_OPEN_EMPTY : ST_OPEN_BUSY;
               ring_put(beat.receive_length);
               ring_put(beat.send_length);
               owed_appends = beat.send_length;
            end
         end
         OPC_APPEND: begin
            if (owed_appends != 0) begin
               ring_put(beat.data_byte);
               owed_appends = owed_appends - 8'd1;
               ans.status = ST_OPEN_BUSY;
            end
         end
         OPC_POP: begin
            // a new sequence needs both headers plus one data byte
            can_pop = (seq_left == 0) ? (occ >= 3) : (occ >= 1);
            if (!can_pop) begin
               ans.status = ST_EMPTY;
               ans.out_byte = EMPTY_BYTE;
            end else begin
               if (seq_left == 0) begin
                  rx_count = ring_take();
                  seq_left = ring_take();
                  ans.first_of_sequence = 1'b1;
               end
               ans.out_byte = ring_take();
               if (seq_left != 0) seq_left = seq_left - 8'd1;
               ans.last_of_sequence = (seq_left == 0);
               ans.status = ST_POPPED;
            end
         end
         default: ;
      endcase
      ans.expected_receive = rx_count;
      last_status = ans.status;
      return ans;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (no_idling) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Drives one request beat and records its expected response on acceptance
   task automatic send(input logic [1:0] op, input logic [7:0] data,
                       input logic [7:0] slen, input logic [7:0] rlen);
      req_item_type beat;
      int           gap;
      beat.opcode         = op;
      beat.data_byte      = data;
      beat.send_length    = slen;
      beat.receive_length = rlen;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= beat.opcode;
      req_ch.data_byte      <= beat.data_byte;
      req_ch.send_length    <= beat.send_length;
      req_ch.receive_length <= beat.receive_length;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      answers_due.push_back(predict_answer(beat));
   endtask

   // Sender holds off until every outstanding response is back
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_answer();
      queue_answer_type want;
      if (answers_due.size() == 0) begin
         $error("response beat with nothing expected");
         failures++;
      end else begin
         want = answers_due.pop_front();
         compare_field("status", 8'(want.status), 8'(rsp_ch.status));
         compare_field("out_byte", want.out_byte, rsp_ch.out_byte);
         compare_field("last_of_sequence", 8'(want.last_of_sequence),
                       8'(rsp_ch.last_of_sequence));
         compare_field("first_of_sequence", 8'(want.first_of_sequence),
                       8'(rsp_ch.first_of_sequence));
         compare_field("expected_receive", want.expected_receive, rsp_ch.expected_receive);
      end
   endfunction

   // Response side: check each beat, then decide next cycle's ready
   initial begin
      rsp_ch.ready <= 1'b0;
      hold_low = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_answer();
         if (hold_low != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_low--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_idling && $urandom_range(0, 3) == 0) hold_low = pick_gap();
         end
      end
   end

   // Pops and appends on an empty queue, unknown opcode, zero-length open
   task automatic test_empty_and_stray();
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_APPEND, 8'hFF, 8'hFF, 8'hFF);
      send(OPC_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      send(OPC_OPEN, 8'h00, 8'h00, 8'h7F);
   endtask

   // Headers without data, open while appends are owed, pop ahead of the data
   task automatic test_sequence_headers();
      send(OPC_OPEN, 8'h00, 8'd2, 8'hFF);
      send(OPC_OPEN, 8'h00, 8'd1, 8'h01);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_APPEND, 8'h00, 8'h00, 8'h00);
      send(OPC_POP, 8'hFF, 8'hFF, 8'hFF);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_APPEND, 8'hFF, 8'h00, 8'h00);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
   endtask

   // Two one-byte sequences queued back to back, second opened on a busy queue
   task automatic test_back_to_back();
      send(OPC_OPEN, 8'h00, 8'd1, 8'h00);
      send(OPC_APPEND, 8'hAA, 8'h00, 8'h00);
      send(OPC_OPEN, 8'h00, 8'd1, 8'h55);
      send(OPC_APPEND, 8'h55, 8'h00, 8'h00);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
      send(OPC_POP, 8'h00, 8'h00, 8'h00);
   endtask

   // Fill the ring to its limit with long sequences, then drain it
   task automatic test_fill_and_drain();
      int room;
      int slen;
      room = RING_DEPTH - 1 - int'(ring_fill());
      while (room >= 3) begin
         if (room - 2 <= 255) begin
            // one byte too many is refused, the exact fit is taken
            send(OPC_OPEN, 8'($urandom), 8'(room - 1), 8'($urandom));
            slen = room - 2;
         end else begin
            slen = $urandom_range(100, 255);
         end
         send(OPC_OPEN, 8'($urandom), 8'(slen), 8'($urandom));
         repeat (slen) send(OPC_APPEND, 8'($urandom), 8'($urandom), 8'($urandom));
         room = RING_DEPTH - 1 - int'(ring_fill());
      end
      send(OPC_OPEN, 8'($urandom), 8'd1, 8'($urandom));
      pause_until_drained();
      do send(OPC_POP, 8'($urandom), 8'($urandom), 8'($urandom));
      while (last_status != ST_EMPTY);
   endtask

   // Mixed traffic, mostly well-formed sequences interleaved with pops and noise
   task automatic test_random_mix(input int beats);
      int pick;
      int slen;
      for (int i = 0; i < beats; i++) begin
         no_idling = (i < beats / 5);
         pick = $urandom_range(0, 99);
         if (owed_appends != 0) begin
            if (pick < 60) send(OPC_APPEND, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 70) send(OPC_OPEN, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 93) send(OPC_POP, 8'($urandom), 8'($urandom), 8'($urandom));
            else send(OPC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            if (pick < 35) begin
               slen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 6);
               send(OPC_OPEN, 8'($urandom), 8'(slen), 8'($urandom));
            end else if (pick < 80) begin
               send(OPC_POP, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 90) begin
               send(OPC_APPEND, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               send(OPC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
            end
         end
      end
      no_idling = 1'b0;
   endtask

   initial begin
      failures     = 0;
      no_idling    = 1'b0;
      shadow_rd    = '0;
      shadow_wr    = '0;
      seq_left     = '0;
      rx_count     = '0;
      owed_appends = '0;
      last_status  = ST_STRAY;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.opcode         <= OPC_OPEN;
      req_ch.data_byte      <= '0;
      req_ch.send_length    <= '0;
      req_ch.receive_length <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_stray();
      test_sequence_headers();
      test_back_to_back();
      pause_until_drained();
      test_fill_and_drain();
      test_random_mix(RANDOM_BEATS);

      // let the last responses come home
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
      repeat (CLOSE_OUT_CYCLES) @(posedge clock);
      if (failures == 0 && answers_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
hdl/fcbq_pkg.sv
hdl/fcbq_channels.sv
hdl/fcbq_ctrl.sv
hdl/fcbq_datapath.sv
hdl/framed_command_byte_queue_unit.sv
bench/tb.sv
